[src/vbs_pkg.sv]
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types, constants and helper functions for vertex bone skinning.
// ----------------------------------------------------------------------------
`default_nettype none

package vbs_pkg;

  localparam int BoneCountDef = 64;
  localparam int FracBitsDef  = 16;
  localparam int WordsPerBone = 12;
  localparam int IdW          = 6;
  localparam int WtW          = 16;
  localparam int WtAccW       = 19;
  localparam int WeightShift  = 15;
  localparam int FifoDepth    = 8;
  localparam int IdxW         = 10;
  // reciprocal of twelve, exact for word addresses 0 to 767
  localparam int RecipTwelve  = 683;
  localparam int RecipShift   = 13;

  typedef enum logic {
    CmdSkin = 1'b0,
    CmdLoad = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [63:0] tex;
    logic        last;
  } meta_t;

  typedef struct packed {
    logic                     first;
    logic                     fin;
    logic signed [WtAccW-1:0] wt;
    meta_t                    meta;
  } ctl_t;

  function automatic logic [2:0] norm_mode(input logic [2:0] raw);
    logic [2:0] r;
    r = raw;
    if (raw == 3'd0) r = 3'd1;
    else if (raw > 3'd4) r = 3'd4;
    return r;
  endfunction

  function automatic logic signed [WtAccW-1:0] bone_weight(input logic [2:0] n,
                                                           input logic [1:0] k,
                                                           input logic [47:0] w);
    logic signed [WtAccW-1:0] w0, w1, w2, one, r;
    w0  = $signed({3'b000, w[15:0]});
    w1  = $signed({3'b000, w[31:16]});
    w2  = $signed({3'b000, w[47:32]});
    one = WtAccW'(32768);
    r   = one;
    case (n)
      3'd2: r = (k == 2'd0) ? one - w0 : w0;
      3'd3: begin
        case (k)
          2'd0:    r = w0;
          2'd1:    r = w1;
          default: r = one - w0 - w1;
        endcase
      end
      3'd4: begin
        case (k)
          2'd0:    r = w0;
          2'd1:    r = w1;
          2'd2:    r = w2;
          default: r = one - w0 - w1 - w2;
        endcase
      end
      default: r = one;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) r = 32'sh7fffffff;
    else if (v < -67'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[src/vertex_bone_skinning.sv]
// ----------------------------------------------------------------------------
// vertex_bone_skinning
// Linear blend skinning of one vertex per transaction over up to four bones.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_stall    command, vertex, ids, weights
//   out       source     out_valid/out_stall  skinned vertex, tex, last
//   cfg       sink       cfg_valid/cfg_ready  influences per vertex
//
// A vertex reads the palette read port once for each bone (1 to 4).
// A palette write gives no result.
// After the last bone read, a result passes datapath stages a to e, then the queue.
// Reset leaves the palette undefined; mode resets to one bone.
// Output stall holds results in an eight-entry queue; input stalls once eight results
// are queued or in flight, and until the current vertex reaches its last bone read.
`default_nettype none

module vertex_bone_skinning #(
  parameter int BoneCount = vbs_pkg::BoneCountDef,
  parameter int FracBits  = vbs_pkg::FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] norm_x_i,
  input  wire logic [31:0] norm_y_i,
  input  wire logic [31:0] norm_z_i,
  input  wire logic [63:0] tex_coords_i,
  input  wire logic [23:0] bone_ids_i,
  input  wire logic [47:0] blend_weights_i,
  input  wire logic [9:0]  palette_index_i,
  input  wire logic        last_vertex_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      out_pos_x_o,
  output logic [31:0]      out_pos_y_o,
  output logic [31:0]      out_pos_z_o,
  output logic [31:0]      out_norm_x_o,
  output logic [31:0]      out_norm_y_o,
  output logic [31:0]      out_norm_z_o,
  output logic [63:0]      out_tex_coords_o,
  output logic             out_last_o
);

  localparam int AW    = (BoneCount > 1) ? $clog2(BoneCount) : 1;
  localparam int CntW  = $clog2(vbs_pkg::FifoDepth + 1);
  localparam int ResW  = 6 * 32 + $bits(vbs_pkg::meta_t);
  localparam int WordN = vbs_pkg::WordsPerBone;

  logic [2:0]         mode_q;
  logic               busy_q;
  logic [1:0]         k_q;
  logic [2:0]         n_q;
  logic [23:0]        ids_q;
  logic [47:0]        w_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] nrm_q [3];
  vbs_pkg::meta_t     meta_q;
  logic [CntW-1:0]    cnt_q;

  logic               last_issue, free, accept, skin, load, pop;
  logic [5:0]         id;
  logic [AW-1:0]      rd_bone;
  vbs_pkg::ctl_t      ctl;
  logic [19:0]        div_prod;
  logic [3:0]         elem;
  logic [AW-1:0]      wr_bone;
  logic               wr_ok;
  logic [31:0]        mat [WordN];

  logic               res_valid;
  logic signed [31:0] res_pos [3];
  logic signed [31:0] res_nrm [3];
  vbs_pkg::meta_t     res_meta;
  logic               q_valid;
  logic [ResW-1:0]    q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  assign last_issue = busy_q && ({1'b0, k_q} == n_q - 3'd1);
  assign free       = !busy_q || last_issue;
  assign in_stall_o = !free || (cnt_q == CntW'(vbs_pkg::FifoDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign skin       = accept && (command_i == vbs_pkg::CmdSkin);
  assign load       = accept && (command_i == vbs_pkg::CmdLoad);
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 3'd1;
      busy_q <= 1'b0;
      k_q    <= '0;
      n_q    <= 3'd1;
      cnt_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (skin) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        n_q    <= vbs_pkg::norm_mode(mode_q);
      end else if (last_issue) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        k_q <= k_q + 2'd1;
      end
      cnt_q <= cnt_q + CntW'(skin) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (skin) begin
      ids_q    <= bone_ids_i;
      w_q      <= blend_weights_i;
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      nrm_q[0] <= norm_x_i;
      nrm_q[1] <= norm_y_i;
      nrm_q[2] <= norm_z_i;
      meta_q   <= '{tex: tex_coords_i, last: last_vertex_i};
    end
  end

  // bone read for the current step; out-of-range ids read bone 0
  assign id      = ids_q[k_q*vbs_pkg::IdW +: vbs_pkg::IdW];
  assign rd_bone = (int'(id) < BoneCount) ? AW'(id) : '0;

  always_comb begin
    ctl.first = (k_q == 2'd0);
    ctl.fin   = last_issue;
    ctl.wt    = vbs_pkg::bone_weight(n_q, k_q, w_q);
    ctl.meta  = meta_q;
  end

  // split word address into bone and element
  assign div_prod = 20'(palette_index_i) * 20'(vbs_pkg::RecipTwelve);
  assign wr_bone  = AW'(div_prod >> vbs_pkg::RecipShift);
  assign elem     = 4'(palette_index_i - 10'(div_prod >> vbs_pkg::RecipShift) * 10'd12);
  assign wr_ok    = load && (int'(palette_index_i) < BoneCount * WordN);

  for (genvar e = 0; e < WordN; e++) begin : g_word
    vbs_ram #(
      .Width (32),
      .Depth (BoneCount)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_ok && (elem == 4'(e))),
      .waddr_i (wr_bone),
      .wdata_i (pos_x_i),
      .raddr_i (rd_bone),
      .rdata_o (mat[e])
    );
  end

  vbs_datapath #(
    .FracBits (FracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (busy_q),
    .pos_i       (pos_q),
    .nrm_i       (nrm_q),
    .ctl_i       (ctl),
    .mat_i       (mat),
    .res_valid_o (res_valid),
    .res_pos_o   (res_pos),
    .res_nrm_o   (res_nrm),
    .res_meta_o  (res_meta)
  );

  assign q_wdata = {res_pos[0], res_pos[1], res_pos[2],
                    res_nrm[0], res_nrm[1], res_nrm[2], res_meta};

  vbs_fifo #(
    .Width (ResW),
    .Depth (vbs_pkg::FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign out_valid_o = q_valid;
  assign {out_pos_x_o, out_pos_y_o, out_pos_z_o,
          out_norm_x_o, out_norm_y_o, out_norm_z_o,
          out_tex_coords_o, out_last_o} = q_rdata;

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(vbs_pkg::FifoDepth)) else $error("credit overrun");
  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0) else $error("result without credit");
  a_skin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skin |=> busy_q && k_q == 2'd0) else $error("vertex not started");

endmodule

`default_nettype wire

[src/vbs_ram.sv]
// ----------------------------------------------------------------------------
// vbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/vbs_fifo.sv]
// ----------------------------------------------------------------------------
// vbs_fifo
// Result queue between the blend stage and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_fifo #(
  parameter int Width = 257,
  parameter int Depth = vbs_pkg::FifoDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [Width-1:0] rdata_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             full;

  assign full    = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push_i || pop_i) else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("result queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

`default_nettype wire

[src/vbs_datapath.sv]
// ----------------------------------------------------------------------------
// vbs_datapath
// Per-bone transform, weighting and blend accumulation, one bone per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_datapath #(
  parameter int FracBits = vbs_pkg::FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               issue_i,
  input  wire logic signed [31:0] pos_i [3],
  input  wire logic signed [31:0] nrm_i [3],
  input  wire vbs_pkg::ctl_t      ctl_i,
  input  wire logic        [31:0] mat_i [vbs_pkg::WordsPerBone],
  output logic                    res_valid_o,
  output logic signed      [31:0] res_pos_o [3],
  output logic signed      [31:0] res_nrm_o [3],
  output vbs_pkg::meta_t          res_meta_o
);

  logic               a_v_q;
  logic signed [31:0] a_pos_q [3];
  logic signed [31:0] a_nrm_q [3];
  vbs_pkg::ctl_t      a_ctl_q;

  logic               b_v_q;
  logic signed [63:0] b_pp_q [3][3];
  logic signed [63:0] b_np_q [3][3];
  logic signed [31:0] b_t_q [3];
  vbs_pkg::ctl_t      b_ctl_q;

  logic               c_v_q;
  logic signed [31:0] c_p_q [3];
  logic signed [31:0] c_n_q [3];
  vbs_pkg::ctl_t      c_ctl_q;

  logic               d_v_q;
  logic signed [50:0] d_p_q [3];
  logic signed [50:0] d_n_q [3];
  vbs_pkg::ctl_t      d_ctl_q;

  logic               e_v_q;
  logic signed [53:0] acc_p_q [3];
  logic signed [53:0] acc_n_q [3];
  vbs_pkg::meta_t     e_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      a_v_q <= issue_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q && d_ctl_q.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pos_q <= pos_i;
    a_nrm_q <= nrm_i;
    a_ctl_q <= ctl_i;
    b_ctl_q <= a_ctl_q;
    c_ctl_q <= b_ctl_q;
    d_ctl_q <= c_ctl_q;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        b_pp_q[c][k] <= (64'(a_pos_q[k]) * 64'($signed(mat_i[k*3+c]))) >>> FracBits;
        b_np_q[c][k] <= (64'(a_nrm_q[k]) * 64'($signed(mat_i[k*3+c]))) >>> FracBits;
      end
      b_t_q[c] <= $signed(mat_i[9+c]);
      c_p_q[c] <= vbs_pkg::sat32(67'(b_pp_q[c][0]) + 67'(b_pp_q[c][1])
                                 + 67'(b_pp_q[c][2]) + 67'(b_t_q[c]));
      c_n_q[c] <= vbs_pkg::sat32(67'(b_np_q[c][0]) + 67'(b_np_q[c][1])
                                 + 67'(b_np_q[c][2]));
      d_p_q[c] <= 51'(c_p_q[c]) * 51'($signed(c_ctl_q.wt));
      d_n_q[c] <= 51'(c_n_q[c]) * 51'($signed(c_ctl_q.wt));
    end
    if (d_v_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_p_q[c] <= d_ctl_q.first ? 54'(d_p_q[c]) : acc_p_q[c] + 54'(d_p_q[c]);
        acc_n_q[c] <= d_ctl_q.first ? 54'(d_n_q[c]) : acc_n_q[c] + 54'(d_n_q[c]);
      end
      e_meta_q <= d_ctl_q.meta;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res_pos_o[c] = vbs_pkg::sat32(67'(acc_p_q[c] >>> vbs_pkg::WeightShift));
      res_nrm_o[c] = vbs_pkg::sat32(67'(acc_n_q[c] >>> vbs_pkg::WeightShift));
    end
  end

  assign res_valid_o = e_v_q;
  assign res_meta_o  = e_meta_q;

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_v_q |-> $past(d_v_q)) else $error("result without a bone");
  a_issue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i |=> a_v_q) else $error("issued bone lost");
  a_first_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v_q && !d_ctl_q.first) |-> $past(d_v_q)) else $error("blend chain broken");

endmodule

`default_nettype wire

[verif/tb_vertex_bone_skinning.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_bone_skinning
// Self-checking bench for the four-bone skinning block: loads bone palettes,
// skins vertices in all modes and compares each result with a local model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vertex_bone_skinning;

  localparam int NumBones = 64;
  localparam int NumWords = NumBones * 12;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] px, py, pz, nx, ny, nz;
    logic [63:0] tex;
    logic [23:0] ids;
    logic [47:0] wts;
    logic [9:0]  addr;
    logic        last;
  } vtx_in_t;

  typedef struct packed {
    logic [31:0] px, py, pz, nx, ny, nz;
    logic [63:0] tex;
    logic        last;
  } vtx_out_t;

  class skin_scoreboard;
    logic [31:0] palette [NumWords];
    bit          loaded [NumWords];
    logic [2:0]  mode;
    vtx_out_t    pending [$];
    int          errors;
    int          checked;

    function new();
      mode = 3'd1;
      errors = 0;
      checked = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function automatic longint floor_div(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function automatic longint bone_comp(int b, longint v[3], int c, bit with_t);
      longint acc;
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += floor_div(v[k] * longint'($signed(palette[b * 12 + k * 3 + c])), 16);
      if (with_t) acc += longint'($signed(palette[b * 12 + 9 + c]));
      return clip32(acc);
    endfunction

    function void note_input(vtx_in_t it);
      int n, b[4];
      longint w[4], p[3], q[3], ap[3], an[3];
      vtx_out_t r;
      if (it.cmd == vbs_pkg::CmdLoad) begin
        if (it.addr < NumWords) begin
          palette[it.addr] = it.px;
          loaded[it.addr] = 1'b1;
        end
        return;
      end
      n = mode == 0 ? 1 : (mode > 4 ? 4 : mode);
      for (int i = 0; i < 4; i++) b[i] = it.ids[6 * i +: 6];
      for (int i = 0; i < 3; i++) w[i] = it.wts[16 * i +: 16];
      if (n == 1) w[0] = 32768;
      else if (n == 2) begin
        w[1] = w[0];
        w[0] = 32768 - w[1];
      end else begin
        w[n - 1] = 32768;
        for (int i = 0; i < n - 1; i++) w[n - 1] -= w[i];
      end
      p = '{longint'($signed(it.px)), longint'($signed(it.py)), longint'($signed(it.pz))};
      q = '{longint'($signed(it.nx)), longint'($signed(it.ny)), longint'($signed(it.nz))};
      ap = '{0, 0, 0};
      an = '{0, 0, 0};
      for (int i = 0; i < n; i++)
        for (int c = 0; c < 3; c++) begin
          ap[c] += bone_comp(b[i], p, c, 1'b1) * w[i];
          an[c] += bone_comp(b[i], q, c, 1'b0) * w[i];
        end
      r.px = 32'(clip32(floor_div(ap[0], 15)));
      r.py = 32'(clip32(floor_div(ap[1], 15)));
      r.pz = 32'(clip32(floor_div(ap[2], 15)));
      r.nx = 32'(clip32(floor_div(an[0], 15)));
      r.ny = 32'(clip32(floor_div(an[1], 15)));
      r.nz = 32'(clip32(floor_div(an[2], 15)));
      r.tex = it.tex;
      r.last = it.last;
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(vtx_out_t got);
      vtx_out_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.px !== e.px) report("pos_x", got.px, e.px);
      if (got.py !== e.py) report("pos_y", got.py, e.py);
      if (got.pz !== e.pz) report("pos_z", got.pz, e.pz);
      if (got.nx !== e.nx) report("norm_x", got.nx, e.nx);
      if (got.ny !== e.ny) report("norm_y", got.ny, e.ny);
      if (got.nz !== e.nz) report("norm_z", got.nz, e.nz);
      if (got.tex !== e.tex) report("tex", got.tex, e.tex);
      if (got.last !== e.last) report("last", got.last, e.last);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_data_i = 3'd0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  vtx_in_t drv = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  vtx_out_t mon;

  skin_scoreboard sb;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 1'b0;
  int quiet = 0;
  int skins = 0;
  bit ready_pal = 1'b0;

  always #5 clk_i = ~clk_i;

  vertex_bone_skinning u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .command_i(drv.cmd), .pos_x_i(drv.px), .pos_y_i(drv.py), .pos_z_i(drv.pz),
    .norm_x_i(drv.nx), .norm_y_i(drv.ny), .norm_z_i(drv.nz),
    .tex_coords_i(drv.tex), .bone_ids_i(drv.ids), .blend_weights_i(drv.wts),
    .palette_index_i(drv.addr), .last_vertex_i(drv.last),
    .out_valid_o, .out_stall_i,
    .out_pos_x_o(mon.px), .out_pos_y_o(mon.py), .out_pos_z_o(mon.pz),
    .out_norm_x_o(mon.nx), .out_norm_y_o(mon.ny), .out_norm_z_o(mon.nz),
    .out_tex_coords_o(mon.tex), .out_last_o(mon.last)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(mon);
    if (rst_ni && out_valid_o && !out_stall_i ||
        in_valid_i && !in_stall_o || cfg_valid_i && cfg_ready_o)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle);
  end

  // valid stays high after acceptance so that items follow back to back;
  // the next idle cycle or drain drops it
  task send(vtx_in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    drv <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    if (it.cmd == vbs_pkg::CmdSkin) skins++;
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_mode(logic [2:0] m);
    drain();
    cfg_data_i <= m;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.mode = m;
  endtask

  task load_word(int a, logic [31:0] v);
    vtx_in_t it;
    it = '0;
    it.cmd = vbs_pkg::CmdLoad;
    it.addr = a;
    it.px = v;
    it.py = $urandom();
    it.tex = {$urandom(), $urandom()};
    send(it);
  endtask

  function automatic logic [31:0] rand_word(bit diag);
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return diag ? 32'h0001_0000 + $urandom_range(32767) - 16384
                           : $signed($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task load_bone(int b);
    for (int e = 0; e < 12; e++)
      load_word(b * 12 + e, (e == 0 || e == 4 || e == 8) ? rand_word(1) :
                (e >= 9 ? $urandom() : rand_word(0)));
  endtask

  function automatic vtx_in_t rand_vertex();
    vtx_in_t it;
    it.cmd = vbs_pkg::CmdSkin;
    it.px = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(1 << 22)) - (1 << 21);
    it.py = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(1 << 22)) - (1 << 21);
    it.pz = $urandom();
    it.nx = $urandom();
    it.ny = $signed($urandom_range(131072)) - 65536;
    it.nz = $urandom();
    it.tex = {$urandom(), $urandom()};
    it.ids = {$urandom()} & 24'hffffff;
    it.wts = {$urandom(), $urandom()};
    if ($urandom_range(1)) it.wts = {3{$urandom_range(16384)}} & 48'hffff_ffff_ffff;
    it.addr = $urandom_range(1023);
    it.last = $urandom_range(1);
    return it;
  endfunction

  task random_phase(int count);
    vtx_in_t it;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) begin
        it = rand_vertex();
        it.cmd = vbs_pkg::CmdLoad;
        it.addr = $urandom_range(1) ? NumWords + $urandom_range(255) : $urandom_range(NumWords - 1);
        send(it);
        if (it.addr < NumWords) sb.loaded[it.addr] = 1'b1;
      end else
        send(rand_vertex());
    end
  endtask

  initial begin
    vtx_in_t it;
    logic [2:0] modes [8];
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int b = 0; b < NumBones; b++) load_bone(b);

    it = rand_vertex();
    it.px = 32'h7fffffff; it.py = 32'h7fffffff; it.pz = 32'h80000000;
    it.nx = 32'h80000000; it.ny = 32'h0; it.nz = 32'hffffffff;
    it.ids = 24'hffffff; it.wts = 48'hffff_ffff_ffff; it.tex = '1; it.last = 1'b1;
    send(it);
    it.ids = 24'h0; it.wts = 48'h0; it.tex = '0; it.last = 1'b0;
    send(it);
    modes = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd6, 3'd1};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      it = rand_vertex();
      it.ids = {6'd9, 6'd9, 6'd63, 6'd9};
      it.wts = 48'hffff_0000_ffff;
      send(it);
      it.wts = 48'h0;
      send(it);
    end
    load_word(NumWords, 32'hdeadbeef);
    load_word(1023, 32'h12345678);

    send_idle = 35; recv_idle = 72;
    for (int m = 1; m <= 4; m++) begin
      write_mode(m[2:0]);
      random_phase(60);
    end
    send_idle = 72; recv_idle = 35;
    for (int m = 4; m >= 1; m--) begin
      write_mode(m[2:0]);
      random_phase(60);
    end
    send_idle = 0; recv_idle = 0;
    write_mode(3'd4);
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      random_phase(40);
    join
    drain();
    random_phase(100);
    write_mode(3'd3);
    random_phase(100);
    write_mode(3'd0);
    random_phase(60);
    drain();

    $display("covered %0d skinned vertices over modes 0 to 7, %0d results checked",
             skins, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire
